### rtl/assert_macros.svh
// Assertion helpers used by the top level; both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KQG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyframe gate check failed");

// Next-cycle implication.
`define KQG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyframe gate check failed");

`endif

### rtl/kqg_pkg.sv
`timescale 1ns / 1ps
package kqg_pkg;

    localparam int FP_LEN       = 64;
    localparam int FP_BITS      = 8;
    localparam int MIN_SELECTED = 3;

    localparam int IDX_W     = $clog2(FP_LEN);
    localparam int CNT_W     = $clog2(FP_LEN + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 * (1 << IDX_W);
    localparam int BYTE_MAX  = (1 << FP_BITS) - 1;
    localparam int SUM_W     = $clog2(FP_LEN * BYTE_MAX + 1);
    localparam int SQ_W      = $clog2(FP_LEN * BYTE_MAX * BYTE_MAX + 1);
    localparam int PROD_W    = CNT_W + SQ_W;
    localparam int VAR_W     = PROD_W + 1;
    localparam int RAD_W     = 2 * PROD_W;
    localparam int ROOT_W    = PROD_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int Q_SHIFT   = 15;
    localparam int NUM_W     = PROD_W + Q_SHIFT;
    localparam int ITER_W    = $clog2(NUM_W + 1);

    localparam logic [16:0] DIST_ONE  = 17'd65536;
    localparam logic [16:0] DIST_HALF = 17'd32768;

    typedef enum logic [3:0] {
        RSN_BLUR         = 4'd0,
        RSN_UNDER        = 4'd1,
        RSN_OVER         = 4'd2,
        RSN_LOW_CONTRAST = 4'd3,
        RSN_START        = 4'd4,
        RSN_SPACING      = 4'd5,
        RSN_DISCONT      = 4'd6,
        RSN_DUPLICATE    = 4'd7,
        RSN_MAX_GAP      = 4'd8,
        RSN_CHANGE       = 4'd9
    } reason_t;

    typedef enum logic [2:0] {
        CFG_SHARP_FLOOR = 3'd0,
        CFG_MIN_LUMA    = 3'd1,
        CFG_MAX_LUMA    = 3'd2,
        CFG_MIN_DEV     = 3'd3,
        CFG_MIN_GAP     = 3'd4,
        CFG_MAX_GAP     = 3'd5,
        CFG_MIN_DIST    = 3'd6,
        CFG_MAX_DIST    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] sharpness_floor;
        logic [15:0] min_luma;
        logic [15:0] max_luma;
        logic [15:0] min_luma_deviation;
        logic [15:0] min_frame_gap;
        logic [15:0] max_frame_gap;
        logic [16:0] min_appearance_distance;
        logic [16:0] max_appearance_distance;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        sharpness_floor:         16'd0,
        min_luma:                16'd0,
        max_luma:                16'hFFFF,
        min_luma_deviation:      16'd0,
        min_frame_gap:           16'd1,
        max_frame_gap:           16'hFFFF,
        min_appearance_distance: 17'd0,
        max_appearance_distance: 17'd65536
    };

    // One finished frame handed from front to back.
    typedef struct packed {
        logic             reject;
        reason_t          reason;
        logic             eoc;
        logic [CNT_W-1:0] n;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sumsq;
        logic [SQ_W-1:0]  xsum;
    } job_t;

    // Decision fed back to the front so it can pick the reference bank.
    typedef struct packed {
        logic valid;
        logic sel;
        logic clear;
    } done_t;

endpackage

### rtl/kqg_ifs.sv
`timescale 1ns / 1ps
interface kqg_item_if;
    logic        valid;
    logic        ready;
    logic [7:0]  fingerprint_byte;
    logic        last_byte;
    logic [15:0] sharpness;
    logic [15:0] mean_luma;
    logic [15:0] luma_deviation;
    logic        end_of_capture;

    modport source (output valid, fingerprint_byte, last_byte, sharpness, mean_luma,
                    luma_deviation, end_of_capture, input ready);
    modport sink   (input valid, fingerprint_byte, last_byte, sharpness, mean_luma,
                    luma_deviation, end_of_capture, output ready);
endinterface

interface kqg_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_index;
    logic        selected;
    logic [3:0]  reason;
    logic [16:0] appearance_distance;
    logic        too_few_selected;

    modport source (output valid, frame_index, selected, reason, appearance_distance,
                    too_few_selected, input ready);
    modport sink   (input valid, frame_index, selected, reason, appearance_distance,
                    too_few_selected, output ready);
endinterface

### rtl/kqg_ram.sv
`timescale 1ns / 1ps
module kqg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/kqg_queue.sv
`timescale 1ns / 1ps
module kqg_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  kqg_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output kqg_pkg::job_t head,
    output logic          avail
);
    import kqg_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    job_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W_Q-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W_Q'(DEPTH));
    assign avail   = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W_Q'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W_Q'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/kqg_front.sv
`timescale 1ns / 1ps
module kqg_front (
    input  logic           clk,
    input  logic           rst_n,
    kqg_item_if.sink       item,
    input  kqg_pkg::cfg_t  cfg,
    input  kqg_pkg::done_t done,
    output kqg_pkg::job_t  job,
    output logic           job_push,
    input  logic           job_full
);
    import kqg_pkg::*;

    logic [CNT_W-1:0]     cnt_reg;
    logic                 bank_reg;
    logic                 busy_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SQ_W-1:0]      sumsq_reg;
    logic [SQ_W-1:0]      cross_reg;

    logic                 s1_valid_reg;
    logic                 s1_last_reg;
    logic                 s1_in_range_reg;
    logic [FP_BITS-1:0]   s1_byte_reg;
    logic [CNT_W-1:0]     s1_n_reg;
    logic                 s1_reject_reg;
    reason_t              s1_reason_reg;
    logic                 s1_eoc_reg;

    logic                 accept;
    logic                 in_range;
    logic [FP_BITS-1:0]   byte_in;
    logic [FP_BITS-1:0]   ref_byte;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 q_reject;
    reason_t              q_reason;
    logic [2*FP_BITS-1:0] sq_term;
    logic [2*FP_BITS-1:0] cross_term;
    logic [SUM_W-1:0]     sum_add;
    logic [SQ_W-1:0]      sumsq_add;
    logic [SQ_W-1:0]      cross_add;

    assign item.ready = !busy_reg && !job_full;
    assign accept     = item.valid && item.ready;
    assign in_range   = (cnt_reg < CNT_W'(FP_LEN));
    assign byte_in    = item.fingerprint_byte[FP_BITS-1:0];
    assign wr_addr    = {~bank_reg, cnt_reg[IDX_W-1:0]};
    assign rd_addr    = {bank_reg, cnt_reg[IDX_W-1:0]};

    kqg_ram #(
        .WIDTH (FP_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && in_range),
        .wr_addr (wr_addr),
        .wr_data (byte_in),
        .rd_en   (accept && in_range),
        .rd_addr (rd_addr),
        .rd_data (ref_byte)
    );

    // Quality screen, in priority order.
    always_comb
    begin
        q_reject = 1'b1;
        q_reason = RSN_START;
        if (cfg.sharpness_floor != '0 && item.sharpness < cfg.sharpness_floor)
        begin
            q_reason = RSN_BLUR;
        end
        else if (item.mean_luma < cfg.min_luma)
        begin
            q_reason = RSN_UNDER;
        end
        else if (item.mean_luma > cfg.max_luma)
        begin
            q_reason = RSN_OVER;
        end
        else if (item.luma_deviation < cfg.min_luma_deviation)
        begin
            q_reason = RSN_LOW_CONTRAST;
        end
        else
        begin
            q_reject = 1'b0;
        end
    end

    assign sq_term    = s1_byte_reg * s1_byte_reg;
    assign cross_term = s1_byte_reg * ref_byte;
    assign sum_add    = sum_reg + SUM_W'(s1_byte_reg);
    assign sumsq_add  = sumsq_reg + SQ_W'(sq_term);
    assign cross_add  = cross_reg + SQ_W'(cross_term);

    assign job_push  = s1_valid_reg && s1_last_reg;
    assign job.reject = s1_reject_reg;
    assign job.reason = s1_reason_reg;
    assign job.eoc    = s1_eoc_reg;
    assign job.n      = s1_n_reg;
    assign job.sum    = s1_in_range_reg ? sum_add : sum_reg;
    assign job.sumsq  = s1_in_range_reg ? sumsq_add : sumsq_reg;
    assign job.xsum   = s1_in_range_reg ? cross_add : cross_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            bank_reg     <= 1'b0;
            busy_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
            sumsq_reg    <= '0;
            cross_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                if (item.last_byte)
                begin
                    cnt_reg <= '0;
                end
                else if (in_range)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            // Hold off the next frame until its reference bank is known.
            if (accept && item.last_byte)
            begin
                busy_reg <= 1'b1;
            end
            else if (done.valid)
            begin
                busy_reg <= 1'b0;
            end
            if (done.valid)
            begin
                if (done.clear)
                begin
                    bank_reg <= 1'b0;
                end
                else if (done.sel)
                begin
                    bank_reg <= ~bank_reg;
                end
            end
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    sum_reg   <= '0;
                    sumsq_reg <= '0;
                    cross_reg <= '0;
                end
                else if (s1_in_range_reg)
                begin
                    sum_reg   <= sum_add;
                    sumsq_reg <= sumsq_add;
                    cross_reg <= cross_add;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg     <= item.last_byte;
            s1_in_range_reg <= in_range;
            s1_byte_reg     <= byte_in;
            s1_n_reg        <= in_range ? cnt_reg + CNT_W'(1) : cnt_reg;
            s1_reject_reg   <= q_reject;
            s1_reason_reg   <= q_reason;
            s1_eoc_reg      <= item.end_of_capture;
        end
    end

endmodule

### rtl/kqg_back.sv
`timescale 1ns / 1ps
module kqg_back (
    input  logic           clk,
    input  logic           rst_n,
    input  kqg_pkg::cfg_t  cfg,
    input  kqg_pkg::job_t  job,
    input  logic           job_avail,
    output logic           job_pop,
    output kqg_pkg::done_t done,
    kqg_result_if.source   result
);
    import kqg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_VPROD,
        ST_SQRT,
        ST_DIV,
        ST_SCALE,
        ST_DECIDE
    } state_t;

    state_t                   state_reg;
    logic [ITER_W-1:0]        step_reg;
    logic [SUM_W-1:0]         sum_st_reg;
    logic [SQ_W-1:0]          sumsq_st_reg;
    logic [15:0]              frame_cnt_reg;
    logic [15:0]              last_sel_reg;
    logic                     have_reg;
    logic [15:0]              total_reg;
    logic signed [VAR_W-1:0]  va_reg;
    logic signed [VAR_W-1:0]  vb_reg;
    logic signed [VAR_W-1:0]  cov_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [ROOT_W-1:0]        drem_reg;
    logic [16:0]              dist_reg;

    logic                     out_valid_reg;
    logic [15:0]              out_index_reg;
    logic                     out_sel_reg;
    reason_t                  out_reason_reg;
    logic [16:0]              out_dist_reg;
    logic                     out_few_reg;

    logic [SUM_W-1:0]         mul_a;
    logic [SQ_W-1:0]          mul_b;
    logic [SUM_W+SQ_W-1:0]    mul_p;
    logic signed [VAR_W-1:0]  mul_s;
    logic [RAD_W-1:0]         vprod;
    logic [REM_W+1:0]         rem_sh;
    logic [REM_W+1:0]         trial;
    logic [REM_W+1:0]         rem_diff;
    logic                     sq_take;
    logic [ROOT_W:0]          dsh;
    logic [ROOT_W:0]          ddiff;
    logic                     dge;
    logic [VAR_W-1:0]         cov_mag;
    logic [16:0]              q_clamp;
    logic [16:0]              dist_calc;
    logic [15:0]              gap;
    logic                     at_max;
    logic                     dec_sel;
    reason_t                  dec_reason;
    logic [15:0]              total_inc;
    logic [15:0]              total_after;
    logic                     dec_few;
    logic                     fire;

    // Shared multiplier for the six moment products.
    always_comb
    begin
        case (step_reg)
            ITER_W'(0): begin mul_a = SUM_W'(job.n); mul_b = sumsq_st_reg; end
            ITER_W'(1): begin mul_a = sum_st_reg;    mul_b = SQ_W'(sum_st_reg); end
            ITER_W'(2): begin mul_a = SUM_W'(job.n); mul_b = job.sumsq; end
            ITER_W'(3): begin mul_a = job.sum;       mul_b = SQ_W'(job.sum); end
            ITER_W'(4): begin mul_a = SUM_W'(job.n); mul_b = job.xsum; end
            default:    begin mul_a = sum_st_reg;    mul_b = SQ_W'(job.sum); end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign mul_s = signed'(mul_p[VAR_W-1:0]);
    assign vprod = va_reg[PROD_W-1:0] * vb_reg[PROD_W-1:0];

    // One root bit per cycle.
    assign rem_sh   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign sq_take  = (rem_sh >= trial);
    assign rem_diff = rem_sh - trial;

    // One quotient bit per cycle.
    assign dsh   = {drem_reg, num_reg[NUM_W-1]};
    assign dge   = (dsh >= {1'b0, root_reg});
    assign ddiff = dsh - {1'b0, root_reg};

    assign cov_mag   = cov_reg[VAR_W-1] ? VAR_W'(-cov_reg) : VAR_W'(cov_reg);
    assign q_clamp   = (num_reg > NUM_W'(DIST_HALF)) ? DIST_HALF : num_reg[16:0];
    assign dist_calc = cov_reg[VAR_W-1] ? DIST_HALF + q_clamp : DIST_HALF - q_clamp;

    assign gap    = frame_cnt_reg - last_sel_reg;
    assign at_max = (gap >= cfg.max_frame_gap);

    always_comb
    begin
        dec_sel    = 1'b0;
        dec_reason = job.reason;
        if (job.reject)
        begin
            dec_reason = job.reason;
        end
        else if (!have_reg)
        begin
            dec_sel    = 1'b1;
            dec_reason = RSN_START;
        end
        else if (gap < cfg.min_frame_gap)
        begin
            dec_reason = RSN_SPACING;
        end
        else if (dist_reg > cfg.max_appearance_distance)
        begin
            dec_reason = RSN_DISCONT;
        end
        else if (at_max ? ({dist_reg, 2'b00} < {2'b00, cfg.min_appearance_distance})
                        : (dist_reg < cfg.min_appearance_distance))
        begin
            dec_reason = RSN_DUPLICATE;
        end
        else
        begin
            dec_sel    = 1'b1;
            dec_reason = at_max ? RSN_MAX_GAP : RSN_CHANGE;
        end
    end

    assign total_inc   = (total_reg != 16'hFFFF) ? total_reg + 16'd1 : total_reg;
    assign total_after = dec_sel ? total_inc : total_reg;
    assign dec_few     = job.eoc && (total_after < 16'(MIN_SELECTED));
    assign fire        = (state_reg == ST_DECIDE) && (!out_valid_reg || result.ready);

    assign job_pop    = fire;
    assign done.valid = fire;
    assign done.sel   = dec_sel;
    assign done.clear = job.eoc;

    assign result.valid               = out_valid_reg;
    assign result.frame_index         = out_index_reg;
    assign result.selected            = out_sel_reg;
    assign result.reason              = out_reason_reg;
    assign result.appearance_distance = out_dist_reg;
    assign result.too_few_selected    = out_few_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            sum_st_reg    <= '0;
            sumsq_st_reg  <= '0;
            frame_cnt_reg <= '0;
            last_sel_reg  <= '0;
            have_reg      <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready && !fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    dist_reg <= '0;
                    if (job_avail)
                    begin
                        state_reg <= (job.reject || !have_reg) ? ST_DECIDE : ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    step_reg <= step_reg + ITER_W'(1);
                    case (step_reg)
                        ITER_W'(0): va_reg  <= mul_s;
                        ITER_W'(1): va_reg  <= va_reg - mul_s;
                        ITER_W'(2): vb_reg  <= mul_s;
                        ITER_W'(3): vb_reg  <= vb_reg - mul_s;
                        ITER_W'(4): cov_reg <= mul_s;
                        default:
                        begin
                            cov_reg   <= cov_reg - mul_s;
                            state_reg <= ST_VPROD;
                        end
                    endcase
                end
                ST_VPROD:
                begin
                    step_reg <= '0;
                    rem_reg  <= '0;
                    root_reg <= '0;
                    rad_reg  <= vprod;
                    if (va_reg[VAR_W-1] || va_reg == '0 || vb_reg[VAR_W-1] || vb_reg == '0)
                    begin
                        dist_reg  <= DIST_ONE;
                        state_reg <= ST_DECIDE;
                    end
                    else
                    begin
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                    rem_reg  <= sq_take ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], sq_take};
                    if (step_reg == ITER_W'(ROOT_W - 1))
                    begin
                        step_reg  <= '0;
                        num_reg   <= {cov_mag[PROD_W-1:0], {Q_SHIFT{1'b0}}};
                        drem_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        step_reg <= step_reg + ITER_W'(1);
                    end
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + ITER_W'(1);
                    drem_reg <= dge ? ddiff[ROOT_W-1:0] : dsh[ROOT_W-1:0];
                    num_reg  <= {num_reg[NUM_W-2:0], dge};
                    if (step_reg == ITER_W'(NUM_W - 1))
                    begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    dist_reg  <= dist_calc;
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if (fire)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_index_reg  <= frame_cnt_reg;
                        out_sel_reg    <= dec_sel;
                        out_reason_reg <= dec_reason;
                        out_dist_reg   <= dist_reg;
                        out_few_reg    <= dec_few;
                        state_reg      <= ST_IDLE;
                        if (job.eoc)
                        begin
                            sum_st_reg    <= '0;
                            sumsq_st_reg  <= '0;
                            frame_cnt_reg <= '0;
                            last_sel_reg  <= '0;
                            have_reg      <= 1'b0;
                            total_reg     <= '0;
                        end
                        else
                        begin
                            if (dec_sel)
                            begin
                                last_sel_reg <= frame_cnt_reg;
                                have_reg     <= 1'b1;
                                total_reg    <= total_inc;
                                sum_st_reg   <= job.sum;
                                sumsq_st_reg <= job.sumsq;
                            end
                            if (frame_cnt_reg != 16'hFFFF)
                            begin
                                frame_cnt_reg <= frame_cnt_reg + 16'd1;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/keyframe_quality_gate.sv
`timescale 1ns / 1ps
// Channel   Role     Beat carries
// item      sink     one fingerprint byte; frame measures on the last byte
// result    source   one decision per frame
// cfg_*     write    register index and data, taken when cfg_wr_en is high
//
// Bytes of a frame are taken one per cycle while the queue has room; a finished frame reaches
// the back via the s1 registers and queue. A distance takes dispatch, six moment products,
// variance product, 29 root steps, 44 divide steps, scale and decide; a non-positive variance
// skips from variance product to decide, rejected and first frames from dispatch to decide.
// The next frame's first byte waits for that decision, as it picks the reference bank; an
// unread result holds the decision. Reset is asynchronous; the store is not cleared.
module keyframe_quality_gate (
    input  logic        clk,
    input  logic        rst_n,
    kqg_item_if.sink    item,
    kqg_result_if.source result,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_wr_data
);
    import kqg_pkg::*;

`include "assert_macros.svh"

    cfg_t  cfg_reg;
    job_t  job_in;
    job_t  job_head;
    logic  job_push;
    logic  job_full;
    logic  job_avail;
    logic  job_pop;
    done_t done;
    logic  sel_reason_ok;
    logic  screen_reason;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SHARP_FLOOR: cfg_reg.sharpness_floor         <= cfg_wr_data[15:0];
                CFG_MIN_LUMA:    cfg_reg.min_luma                <= cfg_wr_data[15:0];
                CFG_MAX_LUMA:    cfg_reg.max_luma                <= cfg_wr_data[15:0];
                CFG_MIN_DEV:     cfg_reg.min_luma_deviation      <= cfg_wr_data[15:0];
                CFG_MIN_GAP:     cfg_reg.min_frame_gap           <= cfg_wr_data[15:0];
                CFG_MAX_GAP:     cfg_reg.max_frame_gap           <= cfg_wr_data[15:0];
                CFG_MIN_DIST:    cfg_reg.min_appearance_distance <= cfg_wr_data;
                CFG_MAX_DIST:    cfg_reg.max_appearance_distance <= cfg_wr_data;
                default:         cfg_reg                         <= cfg_reg;
            endcase
        end
    end

    kqg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg      (cfg_reg),
        .done     (done),
        .job      (job_in),
        .job_push (job_push),
        .job_full (job_full)
    );

    kqg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .head      (job_head),
        .avail     (job_avail)
    );

    kqg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (job_head),
        .job_avail (job_avail),
        .job_pop   (job_pop),
        .done      (done),
        .result    (result)
    );

    assign sel_reason_ok = (result.reason == RSN_START) || (result.reason == RSN_MAX_GAP)
                           || (result.reason == RSN_CHANGE);
    assign screen_reason = (result.reason < RSN_SPACING);

    `KQG_ASSERT_IMPL(a_no_overflow, job_push, !job_full)
    `KQG_ASSERT_NEXT(a_hold_after_frame, item.valid && item.ready && item.last_byte, !item.ready)
    `KQG_ASSERT_IMPL(a_sel_reason, result.valid && result.selected, sel_reason_ok)
    `KQG_ASSERT_IMPL(a_dist_unused, result.valid && screen_reason, result.appearance_distance == '0)
    `KQG_ASSERT_IMPL(a_dist_range, result.valid, result.appearance_distance <= DIST_ONE)

endmodule

### tb/tb_keyframe_quality_gate.sv
`timescale 1ns / 1ps
module tb_keyframe_quality_gate;
    import kqg_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_ITEMS = 1200;
    localparam int NUM_PHASES = 5;

    typedef struct packed {
        logic [15:0] idx;
        logic        sel;
        reason_t     rsn;
        logic [16:0] adist;
        logic        few;
    } decision_t;

    typedef struct {
        logic [7:0]  b;
        int          reps;
        bit          last;
        logic [15:0] sh;
        logic [15:0] mn;
        logic [15:0] dv;
        bit          eoc;
        bit          load_cfg;
        bit          typed;
        decision_t   want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_wr_data = '0;

    kqg_item_if   item ();
    kqg_result_if result ();

    keyframe_quality_gate i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow of the gate state
    cfg_t        cfg;
    logic [7:0]  fp_mem [128];
    int unsigned cur_bank_sel, nbytes, s_cur, s_sto, q_cur, q_sto, x_sum;
    int unsigned fcount, last_sel, sel_total, kept_len;
    bit          have_sel;

    decision_t decision_q[$];
    int        mismatches = 0;
    int        cycles = 0;
    int        beats = 0;
    int        snd_idle = 0;
    int        rcv_idle = 0;
    dir_row_t  dir_rows[10];

    function automatic void clear_capture();
        cur_bank_sel = 0;
        nbytes = 0;
        s_cur = 0;
        s_sto = 0;
        q_cur = 0;
        q_sto = 0;
        x_sum = 0;
        fcount = 0;
        last_sel = 0;
        have_sel = 0;
        sel_total = 0;
    endfunction

    function automatic logic [16:0] corr_distance();
        longint n, sx, sy, va, vb, cov, q;
        longint unsigned v, root, bit_w;
        n = nbytes;
        sx = s_sto;
        sy = s_cur;
        va = n * longint'(q_sto) - sx * sx;
        vb = n * longint'(q_cur) - sy * sy;
        cov = n * longint'(x_sum) - sx * sy;
        if (va <= 0 || vb <= 0)
            return DIST_ONE;
        v = longint'(va) * longint'(vb);
        root = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w >>= 2;
        while (bit_w != 0)
        begin
            if (v >= root + bit_w)
            begin
                v -= root + bit_w;
                root = (root >> 1) + bit_w;
            end
            else
                root >>= 1;
            bit_w >>= 2;
        end
        if (root == 0)
            return DIST_ONE;
        q = (cov * 32768) / longint'(root);
        if (q > 32768)
            q = 32768;
        if (q < -32768)
            q = -32768;
        return 17'(32768 - q);
    endfunction

    function automatic bit predict_decision(input logic [7:0] b, input bit last,
                                            input logic [15:0] sh, input logic [15:0] mn,
                                            input logic [15:0] dv, input bit eoc,
                                            output decision_t d);
        int unsigned gap;
        bit at_max;
        d = '0;
        if (nbytes < FP_LEN)
        begin
            fp_mem[(cur_bank_sel ^ 1) * 64 + nbytes] = b;
            s_cur += b;
            q_cur += b * b;
            x_sum += b * fp_mem[cur_bank_sel * 64 + nbytes];
            nbytes++;
        end
        if (!last)
            return 0;
        gap = fcount - last_sel;
        d.idx = fcount[15:0];
        if (cfg.sharpness_floor != 0 && sh < cfg.sharpness_floor)
            d.rsn = RSN_BLUR;
        else if (mn < cfg.min_luma)
            d.rsn = RSN_UNDER;
        else if (mn > cfg.max_luma)
            d.rsn = RSN_OVER;
        else if (dv < cfg.min_luma_deviation)
            d.rsn = RSN_LOW_CONTRAST;
        else if (!have_sel)
        begin
            d.sel = 1;
            d.rsn = RSN_START;
        end
        else
        begin
            d.adist = corr_distance();
            at_max = gap >= cfg.max_frame_gap;
            if (gap < cfg.min_frame_gap)
                d.rsn = RSN_SPACING;
            else if (d.adist > cfg.max_appearance_distance)
                d.rsn = RSN_DISCONT;
            else if (at_max ? ({d.adist, 2'b00} < {2'b00, cfg.min_appearance_distance})
                            : (d.adist < cfg.min_appearance_distance))
                d.rsn = RSN_DUPLICATE;
            else
            begin
                d.sel = 1;
                d.rsn = at_max ? RSN_MAX_GAP : RSN_CHANGE;
            end
        end
        if (d.sel)
        begin
            last_sel = fcount;
            have_sel = 1;
            if (sel_total < 65535)
                sel_total++;
            cur_bank_sel ^= 1;
            s_sto = s_cur;
            q_sto = q_cur;
            kept_len = nbytes;
        end
        if (fcount < 65535)
            fcount++;
        nbytes = 0;
        s_cur = 0;
        q_cur = 0;
        x_sum = 0;
        if (eoc)
        begin
            d.few = sel_total < MIN_SELECTED;
            clear_capture();
        end
        return 1;
    endfunction

    task automatic send_beat(input logic [7:0] b, input bit last, input logic [15:0] sh,
                             input logic [15:0] mn, input logic [15:0] dv, input bit eoc,
                             input bit typed, input decision_t want);
        decision_t d;
        while ($urandom_range(99) < snd_idle)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid <= 1'b1;
        item.fingerprint_byte <= b;
        item.last_byte <= last;
        item.sharpness <= sh;
        item.mean_luma <= mn;
        item.luma_deviation <= dv;
        item.end_of_capture <= eoc;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        beats++;
        if (predict_decision(b, last, sh, mn, dv, eoc, d))
            decision_q.insert(decision_q.size(), typed ? want : d);
    endtask

    task automatic write_config(input cfg_t c);
        logic [16:0] vals[8];
        vals = '{c.sharpness_floor, c.min_luma, c.max_luma, c.min_luma_deviation,
                 c.min_frame_gap, c.max_frame_gap, c.min_appearance_distance,
                 c.max_appearance_distance};
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wr_data <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        cfg = c;
    endtask

    task automatic drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (decision_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one frame; mode 0 random, 1 near copy, 2 exact copy, 3 inverted, 4 flat
    task automatic send_frame();
        int len, mode, fresh;
        logic [15:0] sh, mn, dv;
        logic [7:0] b, ref_b;
        bit eoc;
        mode = $urandom_range(4);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: len = $urandom_range(2, 16);
            5, 6, 7:       len = $urandom_range(17, 64);
            8:             len = $urandom_range(65, 70);
            default:       len = 1;
        endcase
        if (mode inside {1, 2, 3} && $urandom_range(3) != 0 && kept_len > 0)
            len = kept_len;
        fresh = $urandom;
        for (int i = 0; i < len; i++)
        begin
            ref_b = fp_mem[cur_bank_sel * 64 + (i % 64)];
            case (mode)
                0: b = $urandom;
                1: b = 8'(int'(ref_b) + $urandom_range(6) - 3);
                2: b = ref_b;
                3: b = ~ref_b;
                default: b = fresh[7:0];
            endcase
            if (i != len - 1)
                send_beat(b, 0, $urandom, $urandom, $urandom, $urandom_range(9) == 0,
                          0, '0);
        end
        if ($urandom_range(99) < 85)
        begin
            sh = $urandom_range(cfg.sharpness_floor, 65535);
            mn = (cfg.min_luma <= cfg.max_luma)
                 ? 16'($urandom_range(cfg.min_luma, cfg.max_luma)) : 16'($urandom);
            dv = $urandom_range(cfg.min_luma_deviation, 65535);
        end
        else
        begin
            sh = $urandom;
            mn = $urandom;
            dv = $urandom;
        end
        eoc = $urandom_range(19) == 0;
        send_beat(b, 1, sh, mn, dv, eoc, 0, '0);
    endtask

    function automatic cfg_t phase_config(input int p);
        cfg_t c;
        case (p)
            0: c = CFG_RESET;
            1: c = '{16'd1000, 16'd5000, 16'd60000, 16'd2000, 16'd2, 16'd4,
                     17'd8000, 17'd50000};
            2: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     17'd65536, 17'd0};
            3: c = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 17'd65536, 17'd65536};
            default:
            begin
                c.sharpness_floor = $urandom_range(0, 40000);
                c.min_luma = $urandom_range(0, 20000);
                c.max_luma = $urandom_range(30000, 65535);
                c.min_luma_deviation = $urandom_range(0, 30000);
                c.min_frame_gap = $urandom_range(1, 6);
                c.max_frame_gap = $urandom_range(c.min_frame_gap, 10);
                c.min_appearance_distance = $urandom_range(0, 20000);
                c.max_appearance_distance = $urandom_range(30000, 65536);
            end
        endcase
        return c;
    endfunction

    always @(posedge clk)
    begin
        decision_t got, want;
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                got = '{result.frame_index, result.selected, reason_t'(result.reason),
                        result.appearance_distance, result.too_few_selected};
                if (decision_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected decision beat %p", got);
                end
                else
                begin
                    want = decision_q.pop_front();
                    if (got.idx !== want.idx || got.sel !== want.sel
                        || got.rsn !== want.rsn || got.adist !== want.adist
                        || got.few !== want.few)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("decision mismatch: expected %p got %p", want, got);
                    end
                end
            end
            result.ready <= $urandom_range(99) >= rcv_idle;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_keyframe_quality_gate: errors");
            $finish;
        end
    end

    initial
    begin
        cfg_t p1;
        decision_t none;
        none = '0;
        item.valid = 1'b0;
        item.fingerprint_byte = '0;
        item.last_byte = 1'b0;
        item.sharpness = '0;
        item.mean_luma = '0;
        item.luma_deviation = '0;
        item.end_of_capture = 1'b0;
        cfg = CFG_RESET;
        foreach (fp_mem[i])
            fp_mem[i] = '0;
        kept_len = 0;
        clear_capture();
        p1 = phase_config(1);

        // both banks get filled first so later frames never read an unwritten entry
        dir_rows[0] = '{8'h00, 70, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 1,
                        '{16'd0, 1'b1, RSN_START, 17'd0, 1'b0}};
        dir_rows[1] = '{8'hFF, 64, 1, 16'h0, 16'h0, 16'h0, 0, 0, 1,
                        '{16'd1, 1'b1, RSN_CHANGE, DIST_ONE, 1'b0}};
        dir_rows[2] = '{8'h80, 1, 0, 16'h0, 16'h0, 16'h0, 1, 0, 0, none};
        dir_rows[3] = '{8'h01, 5, 1, 16'h1234, 16'h8000, 16'h0400, 0, 0, 0, none};
        dir_rows[4] = '{8'h10, 1, 1, 16'h0, 16'd30000, 16'd30000, 0, 1, 1,
                        '{16'd3, 1'b0, RSN_BLUR, 17'd0, 1'b0}};
        dir_rows[5] = '{8'h20, 1, 1, 16'hFFFF, 16'h0, 16'd30000, 0, 0, 1,
                        '{16'd4, 1'b0, RSN_UNDER, 17'd0, 1'b0}};
        dir_rows[6] = '{8'h30, 1, 1, 16'hFFFF, 16'hFFFF, 16'd30000, 0, 0, 1,
                        '{16'd5, 1'b0, RSN_OVER, 17'd0, 1'b0}};
        dir_rows[7] = '{8'h40, 1, 1, 16'hFFFF, 16'd30000, 16'h0, 0, 0, 1,
                        '{16'd6, 1'b0, RSN_LOW_CONTRAST, 17'd0, 1'b0}};
        dir_rows[8] = '{8'h5A, 9, 1, 16'hFFFF, 16'd30000, 16'd30000, 1, 0, 0, none};
        dir_rows[9] = '{8'h77, 3, 1, 16'hFFFF, 16'd30000, 16'hFFFF, 1, 0, 1,
                        '{16'd0, 1'b1, RSN_START, 17'd0, 1'b1}};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].load_cfg)
            begin
                drain();
                write_config(p1);
            end
            for (int k = 0; k < dir_rows[r].reps; k++)
                send_beat(dir_rows[r].b, dir_rows[r].last && k == dir_rows[r].reps - 1,
                          dir_rows[r].sh, dir_rows[r].mn, dir_rows[r].dv, dir_rows[r].eoc,
                          dir_rows[r].typed && k == dir_rows[r].reps - 1,
                          dir_rows[r].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            int start_n;
            drain();
            write_config(phase_config(p == 0 ? 4 : p));
            case (p)
                0, 1: begin snd_idle = 34; rcv_idle = 80; end
                2, 3: begin snd_idle = 80; rcv_idle = 34; end
                default: begin snd_idle = 0; rcv_idle = 0; end
            endcase
            start_n = beats;
            while (beats - start_n < RANDOM_ITEMS / NUM_PHASES)
                send_frame();
        end
        // return to the power-on values and finish with a quiet stretch
        drain();
        write_config(CFG_RESET);
        snd_idle = 0;
        rcv_idle = 0;
        repeat (10) send_frame();
        drain();

        if (mismatches == 0 && decision_q.size() == 0)
            $display("tb_keyframe_quality_gate: clean");
        else
            $display("tb_keyframe_quality_gate: errors");
        $finish;
    end
endmodule
